### hw/rtl/point_cloud_to_scan_binning_macros.svh
// Assertion macros for the point-cloud-to-scan binning block.
// Expects clk and arst_n in the scope of use.
`ifndef POINT_CLOUD_TO_SCAN_BINNING_MACROS_SVH
`define POINT_CLOUD_TO_SCAN_BINNING_MACROS_SVH

// Same-cycle implication.
`define PCSB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PCSB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/pcsb_pkg.sv
// Shared types, constants and the arctangent table of the scan binning block.
// No dependencies.
package pcsb_pkg;

	localparam int MAX_BINS_DEF     = 256;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int SQRT_STEPS       = 16;
	localparam int CW               = 29;
	localparam int AC_W             = 28;
	localparam int IDX_W            = 12;

	localparam logic [15:0] NO_RET = 16'hFFFF;
	localparam logic signed [AC_W-1:0] HALF_PI_Q24 = 28'sd26353589;

	localparam logic signed [26:0] ANGLE_MIN_RST = -27'sd18280606;
	localparam logic [23:0]        BPR_RST       = 24'd6736380;
	localparam logic [8:0]         NBINS_RST     = 9'd225;

	typedef struct packed {
		logic              func;
		logic signed [15:0] point_x;
		logic signed [15:0] point_z;
		logic [7:0]        bin_index;
	} pt_t;

	typedef struct packed {
		logic [15:0] range_mm;
		logic        no_return;
	} scan_t;

	typedef struct packed {
		logic signed [26:0] angle_min_q24;
		logic [23:0]        bins_per_radian_q16;
		logic [8:0]         bins_in_use;
	} cfg_t;

	typedef struct packed {
		logic       func;
		logic [7:0] bin_index;
		logic       zero;
	} tag_t;

	typedef struct packed {
		logic                   func;
		logic [7:0]             bin_index;
		logic signed [AC_W-1:0] angle;
		logic [15:0]            range_mm;
	} cp_t;

	typedef struct packed {
		logic             func;
		logic             hit;
		logic [IDX_W-1:0] addr;
		logic [15:0]      range_mm;
	} map_t;

	function automatic logic signed [AC_W-1:0] atan_q24(input int unsigned k);
		logic signed [AC_W-1:0] r;
		case (k)
			0:  r = 28'sd13176795;
			1:  r = 28'sd7778716;
			2:  r = 28'sd4110060;
			3:  r = 28'sd2086331;
			4:  r = 28'sd1047214;
			5:  r = 28'sd524117;
			6:  r = 28'sd262123;
			7:  r = 28'sd131069;
			8:  r = 28'sd65536;
			9:  r = 28'sd32768;
			10: r = 28'sd16384;
			11: r = 28'sd8192;
			12: r = 28'sd4096;
			13: r = 28'sd2048;
			14: r = 28'sd1024;
			15: r = 28'sd512;
			16: r = 28'sd256;
			17: r = 28'sd128;
			18: r = 28'sd64;
			19: r = 28'sd32;
			20: r = 28'sd16;
			21: r = 28'sd8;
			22: r = 28'sd4;
			23: r = 28'sd2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/point_cloud_to_scan_binning.sv
// Top level of the point-cloud-to-scan binning block: APB registers and stage wiring.
// Depends on pcsb_pkg, pcsb_cordic_pipe, pcsb_bin_map and pcsb_bin_mem.
//
// Accepts one item per cycle while pt_stall is low, add or read, and returns one
// transfer per read in item order. An item runs through the input register, the
// CORDIC and square-root stages, the three-stage bin mapping, the bin memory read
// and the output register. After reset all MAX_BINS bins of the memory are swept
// to no-return, and pt_stall is high during the sweep. A stall on the result
// channel holds the whole pipeline.
module point_cloud_to_scan_binning import pcsb_pkg::*; #(
	parameter int MAX_BINS     = MAX_BINS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pt_valid,
	output logic        pt_stall,
	input  pt_t         pt,
	output logic        scan_valid,
	input  logic        scan_stall,
	output scan_t       scan,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [1:0] REG_ANGLE_MIN = 2'd0;
	localparam logic [1:0] REG_BPR       = 2'd1;
	localparam logic [1:0] REG_NBINS     = 2'd2;

	cfg_t cfg_q;
	logic adv, clearing, cp_valid, map_valid;
	cp_t  cp;
	map_t map;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_min_q24       <= ANGLE_MIN_RST;
			cfg_q.bins_per_radian_q16 <= BPR_RST;
			cfg_q.bins_in_use         <= NBINS_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_ANGLE_MIN: cfg_q.angle_min_q24       <= pwdata[26:0];
				REG_BPR:       cfg_q.bins_per_radian_q16 <= pwdata[23:0];
				REG_NBINS:     cfg_q.bins_in_use         <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ANGLE_MIN: prdata = {5'd0, cfg_q.angle_min_q24};
			REG_BPR:       prdata = {8'd0, cfg_q.bins_per_radian_q16};
			REG_NBINS:     prdata = {23'd0, cfg_q.bins_in_use};
			default:       prdata = '0;
		endcase
	end

	assign adv      = !(scan_valid && scan_stall);
	assign pt_stall = !adv || clearing;

	pcsb_cordic_pipe #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (pt_valid && !clearing),
		.in_pt     (pt),
		.out_valid (cp_valid),
		.out_cp    (cp)
	);

	pcsb_bin_map #(.MAX_BINS(MAX_BINS)) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg_q),
		.in_valid  (cp_valid),
		.in_cp     (cp),
		.out_valid (map_valid),
		.out_map   (map)
	);

	pcsb_bin_mem #(.MAX_BINS(MAX_BINS)) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (map_valid),
		.in_map    (map),
		.clearing  (clearing),
		.out_valid (scan_valid),
		.out_scan  (scan)
	);

endmodule

### hw/rtl/pcsb_cordic_pipe.sv
// Pipelined vectoring CORDIC for bearing and bit-per-stage square root for range.
// Depends on pcsb_pkg.
module pcsb_cordic_pipe import pcsb_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic in_valid,
	input  pt_t  in_pt,
	output logic out_valid,
	output cp_t  out_cp
);

	localparam int NST = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

	logic                   v_s    [NST+1];
	tag_t                   tag_s  [NST+1];
	logic signed [CW-1:0]   re_s   [NST+1];
	logic signed [CW-1:0]   im_s   [NST+1];
	logic signed [AC_W-1:0] acc_s  [NST+1];
	logic [31:0]            rem_s  [NST+1];
	logic [31:0]            root_s [NST+1];
	logic [30:0]            sqz_s0;

	logic signed [CW-1:0]   re0, im0;
	logic signed [AC_W-1:0] acc0;
	logic signed [31:0]     sqx_c, sqz_c;

	always_comb begin
		re0   = CW'(in_pt.point_z) <<< 10;
		im0   = CW'(in_pt.point_x) <<< 10;
		acc0  = '0;
		sqx_c = 32'(in_pt.point_x) * 32'(in_pt.point_x);
		sqz_c = 32'(in_pt.point_z) * 32'(in_pt.point_z);
		if (in_pt.point_z < 0) begin
			if (in_pt.point_x >= 0) begin
				re0  = CW'(in_pt.point_x) <<< 10;
				im0  = -(CW'(in_pt.point_z) <<< 10);
				acc0 = HALF_PI_Q24;
			end else begin
				re0  = -(CW'(in_pt.point_x) <<< 10);
				im0  = CW'(in_pt.point_z) <<< 10;
				acc0 = -HALF_PI_Q24;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s[0]  <= '{func: in_pt.func, bin_index: in_pt.bin_index,
				zero: (in_pt.point_x == 16'sd0) && (in_pt.point_z == 16'sd0)};
			re_s[0]   <= re0;
			im_s[0]   <= im0;
			acc_s[0]  <= acc0;
			rem_s[0]  <= {1'b0, sqx_c[30:0]};
			sqz_s0    <= sqz_c[30:0];
			root_s[0] <= '0;
		end
	end

	for (genvar k = 0; k < NST; k++) begin : g_stage
		localparam int SH = (k < SQRT_STEPS) ? (30 - 2 * k) : 0;
		logic signed [CW-1:0]   re_n, im_n;
		logic signed [AC_W-1:0] acc_n;
		logic [31:0]            rem_n, root_n, n_in, trial;

		if (k == 0) begin : g_sum
			assign n_in = rem_s[0] + {1'b0, sqz_s0};
		end else begin : g_pass
			assign n_in = rem_s[k];
		end

		always_comb begin
			re_n   = re_s[k];
			im_n   = im_s[k];
			acc_n  = acc_s[k];
			rem_n  = n_in;
			root_n = root_s[k];
			trial  = root_s[k] + (32'd1 << SH);
			if (k < CORDIC_STEPS) begin
				if (!im_s[k][CW-1]) begin
					re_n  = re_s[k] + (im_s[k] >>> k);
					im_n  = im_s[k] - (re_s[k] >>> k);
					acc_n = acc_s[k] + atan_q24(k);
				end else begin
					re_n  = re_s[k] - (im_s[k] >>> k);
					im_n  = im_s[k] + (re_s[k] >>> k);
					acc_n = acc_s[k] - atan_q24(k);
				end
			end
			if (k < SQRT_STEPS) begin
				if (n_in >= trial) begin
					rem_n  = n_in - trial;
					root_n = (root_s[k] >> 1) + (32'd1 << SH);
				end else begin
					root_n = root_s[k] >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				tag_s[k+1]  <= tag_s[k];
				re_s[k+1]   <= re_n;
				im_s[k+1]   <= im_n;
				acc_s[k+1]  <= acc_n;
				rem_s[k+1]  <= rem_n;
				root_s[k+1] <= root_n;
			end
		end
	end

	assign out_valid           = v_s[NST];
	assign out_cp.func         = tag_s[NST].func;
	assign out_cp.bin_index    = tag_s[NST].bin_index;
	assign out_cp.angle        = tag_s[NST].zero ? '0 : acc_s[NST];
	assign out_cp.range_mm     = root_s[NST][15:0];

endmodule

### hw/rtl/pcsb_bin_map.sv
// Bearing-to-bin mapping: offset, split multiply and range check over three stages.
// Depends on pcsb_pkg.
module pcsb_bin_map import pcsb_pkg::*; #(
	parameter int MAX_BINS = MAX_BINS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  cfg_t cfg,
	input  logic in_valid,
	input  cp_t  in_cp,
	output logic out_valid,
	output map_t out_map
);

	localparam logic [IDX_W-1:0] MAXB = IDX_W'(MAX_BINS);

	logic signed [AC_W:0] diff_c;
	logic                 v_s1, v_s2, v_s3;
	logic                 func_s1, func_s2;
	logic [7:0]           bidx_s1, bidx_s2;
	logic [15:0]          rng_s1, rng_s2;
	logic                 neg_s1, neg_s2;
	logic [AC_W-1:0]      diff_s1;
	logic [AC_W+11:0]     ph_s2, pl_s2;
	logic [51:0]          prod_c;
	logic [IDX_W-1:0]     idx_c, nb_c, bidx_c;
	map_t                 map_s3;

	assign diff_c = (AC_W+1)'(in_cp.angle) - (AC_W+1)'(cfg.angle_min_q24);

	always_comb begin
		prod_c = {ph_s2, 12'd0} + 52'(pl_s2);
		idx_c  = prod_c[51:40];
		nb_c   = ({3'd0, cfg.bins_in_use} > MAXB) ? MAXB : {3'd0, cfg.bins_in_use};
		bidx_c = {4'd0, bidx_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= in_cp.func;
			bidx_s1 <= in_cp.bin_index;
			rng_s1  <= in_cp.range_mm;
			neg_s1  <= diff_c[AC_W];
			diff_s1 <= diff_c[AC_W-1:0];

			func_s2 <= func_s1;
			bidx_s2 <= bidx_s1;
			rng_s2  <= rng_s1;
			neg_s2  <= neg_s1;
			ph_s2   <= diff_s1 * cfg.bins_per_radian_q16[23:12];
			pl_s2   <= diff_s1 * cfg.bins_per_radian_q16[11:0];

			map_s3.func     <= func_s2;
			map_s3.range_mm <= rng_s2;
			map_s3.addr     <= func_s2 ? bidx_c : idx_c;
			map_s3.hit      <= func_s2 ? (bidx_c < nb_c) : (!neg_s2 && (idx_c < nb_c));
		end
	end

	assign out_valid = v_s3;
	assign out_map   = map_s3;

endmodule

### hw/rtl/pcsb_bin_mem.sv
// Bin memory with read-modify-write, forwarding, clear-after-reset sweep and output register.
// Depends on pcsb_pkg and point_cloud_to_scan_binning_macros.svh.
`include "point_cloud_to_scan_binning_macros.svh"
module pcsb_bin_mem import pcsb_pkg::*; #(
	parameter int MAX_BINS = MAX_BINS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  in_valid,
	input  map_t  in_map,
	output logic  clearing,
	output logic  out_valid,
	output scan_t out_scan
);

	localparam int AW = $clog2(MAX_BINS);

	logic [15:0]   mem [MAX_BINS];
	logic [15:0]   rdata_s;
	logic          v_s;
	map_t          map_s;
	logic          wr_v_q;
	logic [AW-1:0] wr_addr_q;
	logic [15:0]   wr_data_q;
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;
	logic [15:0]   cur, wdata, val;
	logic          we;
	scan_t         scan_q;
	logic          scan_v_q;

	always_comb begin
		cur   = (wr_v_q && (wr_addr_q == map_s.addr[AW-1:0])) ? wr_data_q : rdata_s;
		wdata = map_s.func ? NO_RET : map_s.range_mm;
		we    = adv && v_s && map_s.hit && (map_s.func || (map_s.range_mm < cur));
		val   = map_s.hit ? cur : NO_RET;
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= NO_RET;
		end else if (we) begin
			mem[map_s.addr[AW-1:0]] <= wdata;
		end
		if (adv) begin
			rdata_s   <= mem[in_map.addr[AW-1:0]];
			map_s     <= in_map;
			wr_addr_q <= map_s.addr[AW-1:0];
			wr_data_q <= wdata;
			scan_q    <= '{range_mm: (val == NO_RET) ? 16'd0 : val,
				no_return: (val == NO_RET)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s        <= 1'b0;
			wr_v_q     <= 1'b0;
			scan_v_q   <= 1'b0;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (adv) begin
				v_s      <= in_valid;
				wr_v_q   <= we;
				scan_v_q <= v_s && map_s.func;
			end
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(MAX_BINS - 1)) begin
					clr_q <= 1'b0;
				end
			end
		end
	end

	assign clearing  = clr_q;
	assign out_valid = scan_v_q;
	assign out_scan  = scan_q;

	`PCSB_ASSERT_NOW(a_no_item_in_sweep, clr_q, !v_s && !in_valid, "item inside clear sweep")
	`PCSB_ASSERT_NEXT(a_sweep_stays_done, !clr_q, !clr_q, "clear sweep restarted")
	`PCSB_ASSERT_NEXT(a_read_clears_bin, adv && v_s && map_s.func && map_s.hit,
		wr_v_q && (wr_data_q == NO_RET), "read did not clear its bin")

endmodule

### verif/point_cloud_to_scan_binning_test.sv
// Self-checking testbench for point_cloud_to_scan_binning: random add and read
// transfers, APB register phases, stall bursts and one long result hold-off.
// Depends on pcsb_pkg and the point_cloud_to_scan_binning RTL.
module point_cloud_to_scan_binning_test import pcsb_pkg::*; ();

	localparam int PERIOD = 12;
	localparam int DRAIN = 40;
	localparam int WATCH_LIMIT = 3000;
	localparam logic FN_ADD = 1'b0;
	localparam logic FN_READ = 1'b1;
	localparam logic [3:0] A_ANGLE = 4'd0;
	localparam logic [3:0] A_BPR = 4'd4;
	localparam logic [3:0] A_NBINS = 4'd8;
	localparam longint QHALF_PI = 26353589;
	localparam longint ARCTAN [16] = '{13176795, 7778716, 4110060, 2086331, 1047214,
		524117, 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pt_valid = 1'b0;
	logic pt_stall;
	pt_t pt = '0;
	logic scan_valid;
	logic scan_stall = 1'b0;
	scan_t scan;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	pt_t pending[$];
	scan_t bin_reads[$];
	logic [15:0] bin_min[256];
	longint min_bearing;
	longint bins_per_rad;
	int bins_reg;
	bit quiet = 1'b0;
	bit hold_go = 1'b0;
	bit hold_done = 1'b0;
	int pt_gap = 0;
	int scan_gap = 0;
	int errors = 0;
	int n_adds = 0;
	int n_reads = 0;
	int idle_cycles = 0;

	point_cloud_to_scan_binning DUT (.*);

	initial begin
		forever #(PERIOD / 2) clk = ~clk;
	end

	function automatic void stage_item(pt_t p);
		pending = {pending, p};
	endfunction

	function automatic longint root_floor(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint bearing(longint x, longint z);
		longint re, im, acc, t, dre, dim;
		re = z * 1024;
		im = x * 1024;
		acc = 0;
		if (re == 0 && im == 0) return 0;
		if (re < 0) begin
			t = re;
			if (im >= 0) begin
				re = im;
				im = -t;
				acc = QHALF_PI;
			end else begin
				re = -im;
				im = t;
				acc = -QHALF_PI;
			end
		end
		for (int i = 0; i < 16; i++) begin
			dre = im >>> i;
			dim = re >>> i;
			if (im >= 0) begin
				re += dre;
				im -= dim;
				acc += ARCTAN[i];
			end else begin
				re -= dre;
				im += dim;
				acc -= ARCTAN[i];
			end
		end
		return acc;
	endfunction

	function automatic void bin_point(pt_t p);
		int nb;
		longint x, z, rng, diff, idx;
		scan_t r;
		nb = bins_reg > 256 ? 256 : bins_reg;
		if (p.func == FN_READ) begin
			r.range_mm = 16'd0;
			r.no_return = 1'b1;
			if (p.bin_index < nb && bin_min[p.bin_index] != NO_RET) begin
				r.range_mm = bin_min[p.bin_index];
				r.no_return = 1'b0;
			end
			if (p.bin_index < nb) bin_min[p.bin_index] = NO_RET;
			bin_reads = {bin_reads, r};
			n_reads++;
		end else begin
			n_adds++;
			x = p.point_x;
			z = p.point_z;
			rng = root_floor(longint'(x * x + z * z));
			diff = bearing(x, z) - min_bearing;
			if (diff < 0) return;
			idx = (diff * bins_per_rad) >> 40;
			if (idx >= nb) return;
			if (rng < bin_min[idx]) bin_min[idx] = rng[15:0];
		end
	endfunction

	function automatic pt_t make_item(logic f);
		pt_t p;
		int nb;
		nb = bins_reg > 256 ? 256 : (bins_reg < 1 ? 1 : bins_reg);
		p.func = f;
		p.point_x = 16'($urandom);
		p.point_z = 16'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			p.point_x = 16'($urandom_range(0, 4000) - 2000);
			p.point_z = 16'($urandom_range(0, 4000));
		end
		p.bin_index = $urandom_range(0, 4) == 0 ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, nb - 1));
		return p;
	endfunction

	function automatic pt_t add_pt(int x, int z);
		pt_t p;
		p = '0;
		p.func = FN_ADD;
		p.point_x = 16'(x);
		p.point_z = 16'(z);
		p.bin_index = 8'($urandom);
		return p;
	endfunction

	function automatic pt_t read_pt(int b);
		pt_t p;
		p = '0;
		p.func = FN_READ;
		p.bin_index = 8'(b);
		p.point_x = 16'($urandom);
		p.point_z = 16'($urandom);
		return p;
	endfunction

	task automatic reg_write(logic [3:0] a, logic [31:0] d);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (a)
			A_ANGLE: min_bearing = longint'(signed'(d[26:0]));
			A_BPR: bins_per_rad = d[23:0];
			default: bins_reg = d[8:0];
		endcase
	endtask

	task automatic drain();
		while (pending.size() != 0 || bin_reads.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic run_phase(int a, int bpr, int nb, int count, bit sweep);
		reg_write(A_ANGLE, a);
		reg_write(A_BPR, bpr);
		reg_write(A_NBINS, nb);
		for (int i = 0; i < count; i++)
			stage_item(make_item($urandom_range(0, 4) == 0 ? FN_READ : FN_ADD));
		if (sweep)
			for (int i = 0; i < 256; i++) stage_item(read_pt(i));
		drain();
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			pt_valid <= 1'b0;
		end else begin
			if (pt_valid && !pt_stall) begin
				bin_point(pending.pop_front());
			end
			if (!pt_valid || !pt_stall) begin
				if (pt_gap > 0) begin
					pt_gap--;
					pt_valid <= 1'b0;
				end else if (pending.size() == 0) begin
					pt_valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 11) == 0) begin
					pt_gap = $urandom_range(0, 4);
					pt_valid <= 1'b0;
				end else begin
					pt_valid <= 1'b1;
					pt <= pending[0];
				end
			end
		end
	end

	always @(posedge clk) begin
		scan_t want;
		if (scan_valid && !scan_stall) begin
			if (bin_reads.size() == 0) begin
				$display("%0t: unexpected transfer range_mm=%0d no_return=%0d",
					$time, scan.range_mm, scan.no_return);
				errors++;
			end else begin
				want = bin_reads.pop_front();
				if (scan.range_mm !== want.range_mm) begin
					$display("%0t: range_mm expected %0d actual %0d",
						$time, want.range_mm, scan.range_mm);
					errors++;
				end
				if (scan.no_return !== want.no_return) begin
					$display("%0t: no_return expected %0d actual %0d",
						$time, want.no_return, scan.no_return);
					errors++;
				end
			end
		end
		if (hold_go && !hold_done) begin
			hold_done = 1'b1;
			scan_gap = 300;
		end
		if (scan_gap > 0) begin
			scan_gap--;
			scan_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			scan_gap = $urandom_range(0, 4);
			scan_stall <= 1'b1;
		end else begin
			scan_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((pt_valid && !pt_stall) || (scan_valid && !scan_stall) || psel || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("point_cloud_to_scan_binning_test failed");
			$finish;
		end
	end

	initial begin
		min_bearing = -18280606;
		bins_per_rad = 6736380;
		bins_reg = 225;
		foreach (bin_min[i]) bin_min[i] = NO_RET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		reg_write(A_ANGLE, 32'(-18280606));
		reg_write(A_BPR, 6736380);
		reg_write(A_NBINS, 225);
		stage_item(read_pt(5));
		stage_item(add_pt(0, 0));
		stage_item(add_pt(32767, 32767));
		stage_item(add_pt(-32768, -32768));
		stage_item(add_pt(32767, -32768));
		stage_item(add_pt(-32768, 32767));
		stage_item(add_pt(0, 32767));
		stage_item(add_pt(0, -32768));
		stage_item(add_pt(-32768, 0));
		stage_item(add_pt(32767, 0));
		stage_item(add_pt(100, 1000));
		stage_item(add_pt(100, 900));
		stage_item(add_pt(-1000, 1000));
		stage_item(add_pt(1000, 1000));
		for (int i = 0; i < 8; i++) stage_item(read_pt(i * 32));
		stage_item(read_pt(255));
		stage_item(read_pt(224));
		drain();
		hold_go = 1'b1;
		run_phase(-18280606, 6736380, 225, 80, 1'b1);
		run_phase(-52707179, 16777215, 256, 80, 1'b1);
		run_phase(52707179, 1, 1, 70, 1'b0);
		run_phase(-52707179, 0, 511, 70, 1'b0);
		run_phase(-20000000, 3000000, 0, 60, 1'b0);
		run_phase(-30000000, 200000, 16, 70, 1'b1);
		quiet = 1'b1;
		run_phase(-18280606, 6736380, 225, 72, 1'b1);
		$display("covered %0d point adds and %0d bin reads over seven register settings",
			n_adds, n_reads);
		$display("including zero bin width, zero and oversize bin counts, and a long result hold");
		if (errors == 0) begin
			$display("point_cloud_to_scan_binning_test passed");
		end else begin
			$display("point_cloud_to_scan_binning_test failed");
		end
		$finish;
	end

endmodule
